### rtl/cfr_pkg.sv
`default_nettype none
package cfr_pkg;

	localparam int FRAME_LEN = 16;
	localparam int BYTE_W    = 8;
	localparam int IDX_W     = 6;
	localparam int ADDR_W    = $clog2(FRAME_LEN);
	localparam int OUT_W     = 16;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

	typedef struct packed {
		logic take;
		logic start_emit;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic frame_end;
		logic sum_ok;
		logic out_free;
		logic k_last;
	} status_t;

endpackage
`default_nettype wire

### rtl/cfr_dp.sv
`default_nettype none
module cfr_dp (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  cfr_pkg::cmd_t         cmd,
	output cfr_pkg::status_t            sts,
	input  wire  [cfr_pkg::BYTE_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output logic [cfr_pkg::OUT_W-1:0]   m_tdata,
	output logic                        m_tlast
);

	logic [cfr_pkg::BYTE_W-1:0] store_q [cfr_pkg::FRAME_LEN];
	logic [cfr_pkg::BYTE_W-1:0] rd_data_q;
	logic [cfr_pkg::BYTE_W-1:0] final_q;
	logic [cfr_pkg::BYTE_W-1:0] sum_q;
	logic [cfr_pkg::IDX_W-1:0]  pos_q;
	logic [cfr_pkg::IDX_W-1:0]  k_q;

	logic                       out_valid_q;
	logic [cfr_pkg::BYTE_W-1:0] out_byte_q;
	logic [cfr_pkg::IDX_W-1:0]  out_idx_q;
	logic                       out_last_q;

	assign sts.frame_end = (pos_q >= cfr_pkg::LAST_IDX);
	assign sts.sum_ok    = (sum_q == s_tdata);
	assign sts.out_free  = !out_valid_q || m_tready;
	assign sts.k_last    = (k_q == cfr_pkg::LAST_IDX);

	// frame store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.take && !sts.frame_end) begin
			store_q[pos_q[cfr_pkg::ADDR_W-1:0]] <= s_tdata;
		end
		rd_data_q <= store_q[k_q[cfr_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.start_emit) begin
			final_q <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (cmd.take) begin
			if (sts.frame_end) begin
				pos_q <= '0;
				sum_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
				sum_q <= sum_q + s_tdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.start_emit) begin
			k_q <= '0;
		end else if (cmd.load_out) begin
			k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_byte_q <= sts.k_last ? final_q : rd_data_q;
			out_idx_q  <= k_q;
			out_last_q <= sts.k_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_idx_q, out_byte_q};
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

### rtl/cfr_ctrl.sv
`default_nettype none
module cfr_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     s_tvalid,
	output logic                    s_tready,
	input  wire  cfr_pkg::status_t  sts,
	output cfr_pkg::cmd_t           cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_WR   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d        = state_q;
		s_tready       = 1'b0;
		cmd.take       = 1'b0;
		cmd.start_emit = 1'b0;
		cmd.load_out   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					if (sts.frame_end && sts.sum_ok) begin
						cmd.start_emit = 1'b1;
						state_d        = ST_RD;
					end
				end
			end
			ST_RD: begin
				state_d = ST_WR;
			end
			ST_WR: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = sts.k_last ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### rtl/checksummed_frame_receiver.sv
// Checksummed frame receiver.
// Slave channel s_*: one received byte per request. Every FRAME_LEN bytes
// form a frame; the last byte must equal the mod-256 sum of the others.
// Master channel m_*: a good frame is replayed byte by byte with its index,
// tlast set on the checksum byte. A bad frame produces no output.
// Input: a non-final byte is taken as soon as it is offered. After a good
// final byte each output byte is read from the frame store (ST_RD), then
// loaded into the output register (ST_WR), which waits while a stalled
// master holds that register; s_tready is low during that drain. Output
// lags the load by one register. Throughput: one byte per cycle inside a
// frame; the replay is read out of the single read port of the frame store.
// Reset (arst_n low) clears position, sum, counter and the output valid;
// the frame store is not cleared. A stalled master holds the output
// register and the emit sequence waits; input is accepted again once the
// last byte of the frame sits in the output register.
`default_nettype none
module checksummed_frame_receiver (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire  [cfr_pkg::BYTE_W-1:0]  s_tdata,  // [7:0] rx_byte
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output logic [cfr_pkg::OUT_W-1:0]   m_tdata,  // [7:0] frame_byte, [13:8] byte_index
	output logic                        m_tlast   // last_byte
);

	cfr_pkg::cmd_t    cmd;
	cfr_pkg::status_t sts;

	cfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cfr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

### tb/sv/tb_checksummed_frame_receiver.sv
`timescale 1ns / 1ps
module tb_checksummed_frame_receiver;

	localparam int BYTE_W      = cfr_pkg::BYTE_W;
	localparam int IDX_W       = cfr_pkg::IDX_W;
	localparam int OUT_W       = cfr_pkg::OUT_W;
	localparam int ADDR_W      = cfr_pkg::ADDR_W;
	localparam int FRAME_LEN   = cfr_pkg::FRAME_LEN;
	localparam logic [IDX_W-1:0] LAST_IDX = cfr_pkg::LAST_IDX;

	localparam int FL          = FRAME_LEN;
	localparam int PAD_LO      = BYTE_W + IDX_W;
	localparam int STALL_LIMIT = 5000;
	localparam int TAIL_CYCLES = 2 * FRAME_LEN + 8;

	typedef struct {
		logic [BYTE_W-1:0] data;
		logic [IDX_W-1:0]  idx;
		logic              last;
	} frame_beat_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [BYTE_W-1:0]  s_tdata  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;
	logic               m_tlast;

	// no random idling on either side while set
	bit steady = 1'b0;

	logic [BYTE_W-1:0]  held_bytes [FL];
	logic [IDX_W-1:0]   rx_pos = '0;
	logic [BYTE_W-1:0]  rx_sum = '0;
	frame_beat_t        good_frame_beats [$];
	frame_beat_t        head;
	int                 mismatch_count = 0;
	int                 stall_cycles = 0;

	checksummed_frame_receiver dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 19);
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// running checksum; a matching final byte replays the whole frame
	function automatic void absorb_rx_byte(input logic [BYTE_W-1:0] b);
		frame_beat_t beat;
		if (rx_pos < LAST_IDX) begin
			held_bytes[rx_pos[ADDR_W-1:0]] = b;
			rx_sum = rx_sum + b;
			rx_pos = rx_pos + 1'b1;
		end else begin
			if (rx_sum == b) begin
				for (int k = 0; k < FL; k++) begin
					beat.data = (k == FL - 1) ? b : held_bytes[k];
					beat.idx  = IDX_W'(k);
					beat.last = (k == FL - 1);
					good_frame_beats.push_back(beat);
				end
			end
			rx_pos = '0;
			rx_sum = '0;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				absorb_rx_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				if (good_frame_beats.size() == 0) begin
					report_mismatch("unexpected request", int'(m_tdata), 0);
				end else begin
					head = good_frame_beats.pop_front();
					if (m_tdata[BYTE_W-1:0] !== head.data)
						report_mismatch("frame_byte", int'(m_tdata[BYTE_W-1:0]),
							int'(head.data));
					if (m_tdata[PAD_LO-1:BYTE_W] !== head.idx)
						report_mismatch("byte_index", int'(m_tdata[PAD_LO-1:BYTE_W]),
							int'(head.idx));
					if (m_tdata[OUT_W-1:PAD_LO] !== '0)
						report_mismatch("tdata pad", int'(m_tdata[OUT_W-1:PAD_LO]), 0);
					if (m_tlast !== head.last)
						report_mismatch("last_byte", int'(m_tlast), int'(head.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("FAILED: results differ");
					$finish;
				end
			end
		end
	end

	task automatic send_rx_byte(input logic [BYTE_W-1:0] b);
		while (!steady && $urandom_range(99) < 19) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic send_random_frame(input bit good);
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] total;
		total = '0;
		for (int i = 0; i < FL - 1; i++) begin
			b = BYTE_W'($urandom);
			total = total + b;
			send_rx_byte(b);
		end
		send_rx_byte(good ? total : total + BYTE_W'($urandom_range(1, 255)));
	endtask

	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (good_frame_beats.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_good_frame_extremes();
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] total;
		total = '0;
		for (int i = 0; i < FL - 1; i++) begin
			case (i % 4)
				0: b = 8'h00;
				1: b = 8'hFF;
				2: b = 8'h55;
				default: b = 8'hAA;
			endcase
			total = total + b;
			send_rx_byte(b);
		end
		send_rx_byte(total);
	endtask

	// all-ones body wraps the sum; an all-ones check byte must not match it
	task automatic test_checksum_mismatch();
		for (int i = 0; i < FL - 1; i++)
			send_rx_byte(8'hFF);
		send_rx_byte(8'hFF);
	endtask

	task automatic test_pause_for_drain();
		send_random_frame(1'b1);
		wait_all_results();
		send_random_frame(1'b1);
	endtask

	task automatic test_random_frames(input int frames);
		for (int f = 0; f < frames; f++) begin
			steady = (f >= 4 && f < 9);
			send_random_frame($urandom_range(99) < 80);
			if ($urandom_range(99) < 10)
				wait_all_results();
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_good_frame_extremes();
		test_checksum_mismatch();
		test_pause_for_drain();
		test_random_frames(16);
		wait_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (good_frame_beats.size() != 0)
			report_mismatch("missing requests", good_frame_beats.size(), 0);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### sim.f
rtl/cfr_pkg.sv
rtl/cfr_dp.sv
rtl/cfr_ctrl.sv
rtl/checksummed_frame_receiver.sv
tb/sv/tb_checksummed_frame_receiver.sv
